/* hw/rtl/utdb_pkg.sv */
// Shared types, constants and codes for the USB transfer descriptor builder.
package utdb_pkg;

  localparam int MAX_DESCRIPTORS = 64;

  localparam int MPS_W  = 10;
  localparam int SIZE_W = 16;
  localparam int ADDR_W = 32;
  localparam int CNT_W  = $clog2(MAX_DESCRIPTORS + 1);
  localparam int LIM_W  = MPS_W + CNT_W;
  localparam int CMP_W  = (LIM_W > SIZE_W) ? LIM_W : SIZE_W;

  // Data descriptor limits: control spends two on setup and status.
  localparam logic [LIM_W-1:0] LIM_CTRL  = LIM_W'(MAX_DESCRIPTORS - 2);
  localparam logic [LIM_W-1:0] LIM_OTHER = LIM_W'(MAX_DESCRIPTORS);

  localparam logic [1:0] OP_CONTROL = 2'd0;
  localparam logic [1:0] OP_INTR_IN = 2'd1;
  localparam logic [1:0] OP_ISO_OUT = 2'd2;
  localparam logic [1:0] OP_NONE    = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ZERO_MPS  = 2'd1;
  localparam logic [1:0] ST_TOO_MANY  = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  localparam logic [7:0] PID_SETUP = 8'h2D;
  localparam logic [7:0] PID_IN    = 8'h69;
  localparam logic [7:0] PID_OUT   = 8'hE1;

  localparam logic [15:0] FLAG_ACTIVE = 16'h0080;
  localparam logic [15:0] FLAG_IOC    = 16'h0100;
  localparam logic [15:0] FLAG_IOS    = 16'h0200;
  localparam logic [15:0] FLAG_ERRCNT = 16'h0800;

  localparam logic [10:0] LEN_MASK = 11'h7FF;

  typedef struct packed {
    logic [1:0]        operation;
    logic              direction_out;
    logic [6:0]        device_address;
    logic [3:0]        endpoint;
    logic [MPS_W-1:0]  packet_bytes;
    logic [SIZE_W-1:0] transfer_size;
    logic [ADDR_W-1:0] data_address;
    logic [ADDR_W-1:0] request_address;
  } in_t;

  typedef struct packed {
    logic [31:0]       token_word;
    logic [31:0]       control_status_word;
    logic [ADDR_W-1:0] buffer_address;
    logic [1:0]        status;
    logic              last;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_ERROR,
    S_SETUP,
    S_DATA,
    S_STATUS
  } state_t;

  typedef enum logic [1:0] {
    SEL_ERROR,
    SEL_SETUP,
    SEL_DATA,
    SEL_STATUS
  } sel_t;

  typedef struct packed {
    logic capture;
    logic load;
    sel_t sel;
  } cmd_t;

  typedef struct packed {
    logic [1:0] err_code;
    logic       skip;
    logic       ctrl;
    logic       rem_zero;
    logic       data_final;
    logic       out_free;
  } stat_t;

endpackage

/* hw/rtl/utdb_ctrl.sv */
// Sequencer: walks a request through check, then an error beat or setup, data and status beats.
module utdb_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  utdb_pkg::stat_t stat,
  output utdb_pkg::cmd_t  cmd
);
  import utdb_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (stat.skip)                 state_nxt = S_IDLE;
        else if (stat.err_code != ST_OK) state_nxt = S_ERROR;
        else if (stat.ctrl)            state_nxt = S_SETUP;
        else                           state_nxt = S_DATA;
      end
      S_ERROR: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      S_SETUP: begin
        if (stat.out_free) state_nxt = stat.rem_zero ? S_STATUS : S_DATA;
      end
      S_DATA: begin
        if (stat.out_free && stat.data_final) begin
          state_nxt = stat.ctrl ? S_STATUS : S_IDLE;
        end
      end
      S_STATUS: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.load    = 1'b0;
    cmd.sel     = SEL_ERROR;
    case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_EVAL: begin
        cmd.load = 1'b0;
      end
      S_ERROR: begin
        cmd.load = stat.out_free;
        cmd.sel  = SEL_ERROR;
      end
      S_SETUP: begin
        cmd.load = stat.out_free;
        cmd.sel  = SEL_SETUP;
      end
      S_DATA: begin
        cmd.load = stat.out_free;
        cmd.sel  = SEL_DATA;
      end
      S_STATUS: begin
        cmd.load = stat.out_free;
        cmd.sel  = SEL_STATUS;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

/* hw/rtl/utdb_dp.sv */
// Datapath: request registers, chunk walker, descriptor assembly, output register.
module utdb_dp (
  input  logic            clk,
  input  logic            rst_n,
  input  utdb_pkg::in_t   in_data,
  input  utdb_pkg::cmd_t  cmd,
  output utdb_pkg::stat_t stat,
  output logic            out_valid,
  input  logic            out_ready,
  output utdb_pkg::out_t  out_data
);
  import utdb_pkg::*;

  // captured request
  logic [1:0]        op_r;
  logic              dir_r;
  logic [6:0]        dev_r;
  logic [3:0]        ep_r;
  logic [MPS_W-1:0]  mps_r;
  logic              size_zero_r;
  logic [ADDR_W-1:0] req_r;
  logic [LIM_W-1:0]  lim_r;
  // walker
  logic [SIZE_W-1:0] rem_r;
  logic [ADDR_W-1:0] addr_r;
  logic              toggle_r;
  // output stage
  out_t              out_r;
  logic              out_valid_r, out_valid_nxt;

  logic              ctrl;
  logic [LIM_W-1:0]  factor;
  logic [1:0]        err;
  logic [MPS_W-1:0]  chunk;
  logic [10:0]       len_m1;
  logic [7:0]        data_pid;
  logic [7:0]        stat_pid;
  logic              final_beat;
  logic [15:0]       flags;
  out_t              beat;

  assign ctrl   = (op_r == OP_CONTROL);
  assign factor = (in_data.operation == OP_CONTROL) ? LIM_CTRL : LIM_OTHER;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r        <= in_data.operation;
      dir_r       <= in_data.direction_out;
      dev_r       <= in_data.device_address;
      ep_r        <= in_data.endpoint;
      mps_r       <= in_data.packet_bytes;
      size_zero_r <= (in_data.transfer_size == '0);
      req_r       <= in_data.request_address;
      lim_r       <= LIM_W'(in_data.packet_bytes) * factor;
      rem_r       <= in_data.transfer_size;
      addr_r      <= in_data.data_address;
      toggle_r    <= (in_data.operation == OP_CONTROL);
    end else if (cmd.load && cmd.sel == SEL_DATA) begin
      rem_r  <= stat.data_final ? '0 : rem_r - SIZE_W'(mps_r);
      addr_r <= addr_r + ADDR_W'(mps_r);
      if (op_r != OP_ISO_OUT) toggle_r <= ~toggle_r;
    end
  end

  // error priority: zero packet size, empty data, too many descriptors
  always_comb begin
    if (mps_r == '0)                                      err = ST_ZERO_MPS;
    else if (!ctrl && size_zero_r)                        err = ST_EMPTY;
    else if (CMP_W'(rem_r) > CMP_W'(lim_r))               err = ST_TOO_MANY;
    else                                                  err = ST_OK;
  end

  assign stat.err_code   = err;
  assign stat.skip       = (op_r == OP_NONE);
  assign stat.ctrl       = ctrl;
  assign stat.rem_zero   = (rem_r == '0);
  assign stat.data_final = (SIZE_W'(mps_r) >= rem_r);
  assign stat.out_free   = !out_valid_r || out_ready;

  assign chunk      = stat.data_final ? rem_r[MPS_W-1:0] : mps_r;
  assign len_m1     = 11'(chunk) - 11'd1;
  assign data_pid   = ctrl ? (dir_r ? PID_OUT : PID_IN)
                           : ((op_r == OP_ISO_OUT) ? PID_OUT : PID_IN);
  assign stat_pid   = (size_zero_r || dir_r) ? PID_IN : PID_OUT;
  assign final_beat = !ctrl && stat.data_final;

  always_comb begin
    flags = FLAG_ACTIVE | FLAG_ERRCNT;
    if (op_r == OP_ISO_OUT) flags = flags | FLAG_IOS;
    if (final_beat)         flags = flags | FLAG_IOC;
  end

  always_comb begin
    beat = '0;
    case (cmd.sel)
      SEL_ERROR: begin
        beat.status = err;
        beat.last   = 1'b1;
      end
      SEL_SETUP: begin
        beat.token_word          = {11'd7, 1'b0, 1'b0, 4'd0, dev_r, PID_SETUP};
        beat.control_status_word = {FLAG_ACTIVE | FLAG_ERRCNT, 5'd0, LEN_MASK};
        beat.buffer_address      = req_r;
      end
      SEL_DATA: begin
        beat.token_word          = {len_m1, 1'b0, toggle_r, ctrl ? 4'd0 : ep_r, dev_r,
                                    data_pid};
        beat.control_status_word = {flags, 5'd0, LEN_MASK};
        beat.buffer_address      = addr_r;
        beat.last                = final_beat;
      end
      SEL_STATUS: begin
        beat.token_word          = {LEN_MASK, 1'b0, 1'b1, 4'd0, dev_r, stat_pid};
        beat.control_status_word = {FLAG_ACTIVE | FLAG_ERRCNT | FLAG_IOC, 5'd0, LEN_MASK};
        beat.last                = 1'b1;
      end
      default: beat = '0;
    endcase
  end

  assign out_valid_nxt = cmd.load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) out_r <= beat;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* hw/rtl/usb_transfer_descriptor_builder.sv */
// Top level of the USB transfer descriptor builder: sequencer plus datapath.
//
//   channel  | ports                      | beat
//   ---------+----------------------------+-------------------------------------
//   in       | in_valid, in_ready, in_data   | one transfer request (in_t)
//   out      | out_valid, out_ready, out_data| one transfer descriptor or error
//
// Flow: a request is captured, checked for errors, then yields D descriptors,
// where D is the number of descriptors made (1 for an error result, 0 for
// operation three). Capture also forms the count limit with a single
// multiply; after the check the output register takes one descriptor per
// cycle unless out_ready stalls it. in_ready is high only between requests.
// Reset: rst_n, synchronous, active low; clears the sequencer and out_valid.
// Stalls: out_ready low holds the output register and the walk waits on it; a
// new request may be taken while the last descriptor of the previous one waits.
//
// The too-many check is size > limit * packet_bytes, so no divider
// is needed; the walker then subtracts packet_bytes per data descriptor.
module usb_transfer_descriptor_builder (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  utdb_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output utdb_pkg::out_t out_data
);
  import utdb_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  utdb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  utdb_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // One request at a time: after capture the input stays closed while the request is evaluated.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted during evaluation");

  // An error result is a lone, final beat with cleared words.
  a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != ST_OK) |->
      (out_data.last && out_data.token_word == '0 && out_data.buffer_address == '0))
    else $error("malformed error beat");

  // The final descriptor of a good request always carries interrupt-on-complete.
  a_last_ioc: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_OK && out_data.last) |->
      out_data.control_status_word[24])
    else $error("last descriptor without IOC");

  // A descriptor loaded while the output waited would overwrite it.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load) |-> (!out_valid || out_ready))
    else $error("output register overwritten");

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the USB transfer descriptor builder.
`timescale 1ns / 1ps

module testbench;
  import utdb_pkg::*;

  // A request yields at most MAX_DESCRIPTORS beats, one per cycle unless stalled,
  // after capture and error checking; the hold-off at the end covers that.
  localparam int HOLD_OFF     = 2 + MAX_DESCRIPTORS + 8;
  // Cycles with no beat on either channel before the run is declared hung.
  // The worst legal lull is a short random stall or sender gap plus capture
  // and error checking, so this is many times over.
  localparam int QUIET_LIMIT  = 5000;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  // Descriptors predicted but not yet seen on the result channel, oldest first.
  out_t pending_descriptors[$];
  int   mismatches     = 0;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;

  usb_transfer_descriptor_builder DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Descriptor prediction
  // ---------------------------------------------------------------------------

  // Token layout: pid [7:0], address [14:8], endpoint [18:15], toggle [19],
  // bit 20 clear, (length - 1) modulo 2048 in [31:21] so a zero length
  // shows as 0x7FF.
  function automatic logic [31:0] token_for(input logic [7:0] pid,
                                            input logic [6:0] dev,
                                            input logic [3:0] ep,
                                            input logic       toggle,
                                            input int         len);
    logic [10:0] len_m1;
    len_m1 = 11'(len - 1);
    return {len_m1, 1'b0, toggle, ep, dev, pid};
  endfunction

  // Control/status word: actual length field always 0x7FF, flags in the top
  // half.
  function automatic void push_descriptor(input logic [31:0] token,
                                          input logic [15:0] flags,
                                          input logic [31:0] buffer,
                                          input logic        is_last);
    out_t d;
    d.token_word          = token;
    d.control_status_word = {flags, 5'b0, LEN_MASK};
    d.buffer_address      = buffer;
    d.status              = ST_OK;
    d.last                = is_last;
    pending_descriptors.push_back(d);
  endfunction

  // A rejected request gives a single all-zero beat carrying the code.
  function automatic void push_error(input logic [1:0] code);
    out_t d;
    d        = '0;
    d.status = code;
    d.last   = 1'b1;
    pending_descriptors.push_back(d);
  endfunction

  // Works out the whole descriptor chain for one accepted request.
  function automatic void chain_for_request(input in_t req);
    logic [7:0]  pid;
    logic [3:0]  ep;
    logic        toggle;
    logic [15:0] base_flags;
    logic [15:0] flags;
    logic [31:0] buf_addr;
    int unsigned xfer_bytes;
    int unsigned mps;
    int unsigned ndata;
    int unsigned total;
    int unsigned offset;
    int unsigned len;
    int unsigned i;
    bit          ctrl;
    bit          is_final;

    xfer_bytes = 32'(req.transfer_size);
    mps        = 32'(req.packet_bytes);
    ctrl       = (req.operation == OP_CONTROL);

    if (req.operation == OP_NONE) return;
    // Error priority: zero packet size, then empty data, then count.
    if (mps == 0) begin
      push_error(ST_ZERO_MPS);
      return;
    end
    if (!ctrl && xfer_bytes == 0) begin
      push_error(ST_EMPTY);
      return;
    end
    ndata = (xfer_bytes + mps - 1) / mps;
    total = ndata + (ctrl ? 2 : 0);
    if (total > MAX_DESCRIPTORS) begin
      push_error(ST_TOO_MANY);
      return;
    end

    base_flags = FLAG_ACTIVE | FLAG_ERRCNT;
    pid        = PID_IN;
    ep         = req.endpoint;
    toggle     = 1'b0;
    if (ctrl) begin
      push_descriptor(token_for(PID_SETUP, req.device_address, 4'd0, 1'b0, 8),
                      base_flags, req.request_address, 1'b0);
      pid    = req.direction_out ? PID_OUT : PID_IN;
      ep     = 4'd0;
      toggle = 1'b1;
    end else if (req.operation == OP_ISO_OUT) begin
      pid        = PID_OUT;
      base_flags = base_flags | FLAG_IOS;
    end

    offset = 0;
    for (i = 0; i < ndata; i++) begin
      len      = (xfer_bytes - offset > mps) ? mps : xfer_bytes - offset;
      is_final = !ctrl && (i + 1 == ndata);
      flags    = is_final ? (base_flags | FLAG_IOC) : base_flags;
      buf_addr = req.data_address + offset;  // wraps at 2^32
      push_descriptor(token_for(pid, req.device_address, ep, toggle, len),
                      flags, buf_addr, is_final);
      if (req.operation != OP_ISO_OUT) toggle = ~toggle;
      offset += mps;
    end

    // Status stage: IN with no data stage, otherwise against the data.
    if (ctrl) begin
      pid = (xfer_bytes == 0 || req.direction_out) ? PID_IN : PID_OUT;
      push_descriptor(token_for(pid, req.device_address, 4'd0, 1'b1, 0),
                      base_flags | FLAG_IOC, 32'd0, 1'b1);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result channel: random stalls and the checker
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic void check_field(input string name,
                                      input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endfunction

  // Each result beat is matched against the oldest prediction.
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_descriptors.size() == 0) begin
        $error("result beat with nothing expected: %h", out_data);
        mismatches++;
      end else begin
        want = pending_descriptors.pop_front();
        check_field("token_word", want.token_word, out_data.token_word);
        check_field("control_status_word", want.control_status_word,
                    out_data.control_status_word);
        check_field("buffer_address", want.buffer_address, out_data.buffer_address);
        check_field("status", 32'(want.status), 32'(out_data.status));
        check_field("last", 32'(want.last), 32'(out_data.last));
      end
    end
  end

  // Watchdog: ends the run if neither channel moves for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("** usb_transfer_descriptor_builder: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Request channel
  // ---------------------------------------------------------------------------

  // Presents one request after a random gap and holds it until the beat is
  // taken. in_valid is left high afterwards so back-to-back requests need
  // only one assignment per edge; a gap lowers it first.
  task automatic send_request(input in_t req);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    chain_for_request(req);
  endtask

  // Holds off the sender until every predicted descriptor has come back.
  task automatic wait_for_chains();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_descriptors.size() != 0) @(posedge clk);
  endtask

  function automatic in_t make_request(input logic [1:0]  op,
                                       input logic        dir_out,
                                       input logic [6:0]  dev,
                                       input logic [3:0]  ep,
                                       input int          mps,
                                       input int          xfer_bytes,
                                       input logic [31:0] data_addr,
                                       input logic [31:0] setup_addr);
    in_t r;
    r.operation       = op;
    r.direction_out   = dir_out;
    r.device_address  = dev;
    r.endpoint        = ep;
    r.packet_bytes    = MPS_W'(mps);
    r.transfer_size   = SIZE_W'(xfer_bytes);
    r.data_address    = data_addr;
    r.request_address = setup_addr;
    return r;
  endfunction

  // Mostly well-formed requests sized to a chosen descriptor count, with a
  // share of rejected requests, ignored operations and raw noise.
  function automatic in_t random_request();
    in_t         r;
    int unsigned pick;
    int unsigned n;
    int unsigned lim;
    int unsigned mps;

    r.direction_out   = 1'($urandom_range(1));
    r.device_address  = 7'($urandom_range(127));
    r.endpoint        = 4'($urandom_range(15));
    r.data_address    = $urandom;
    r.request_address = $urandom;
    pick = $urandom_range(99);

    if (pick < 80) begin
      case ($urandom_range(2))
        0:       r.operation = OP_CONTROL;
        1:       r.operation = OP_INTR_IN;
        default: r.operation = OP_ISO_OUT;
      endcase
      lim = (r.operation == OP_CONTROL) ? MAX_DESCRIPTORS - 2 : MAX_DESCRIPTORS;
      n   = ($urandom_range(9) == 0) ? $urandom_range(lim, 1) : $urandom_range(6, 1);
      if (r.operation == OP_CONTROL && $urandom_range(7) == 0) n = 0;
      mps = ($urandom_range(3) == 0) ? $urandom_range(16, 1) : $urandom_range(1023, 1);
      r.packet_bytes    = MPS_W'(mps);
      // At most 64 * 1023 bytes, which fits the size field.
      r.transfer_size   = (n == 0) ? '0 : SIZE_W'((n - 1) * mps + $urandom_range(mps, 1));
    end else if (pick < 88) begin
      case ($urandom_range(2))
        0: begin  // zero packet size
          r.operation       = ($urandom_range(2) == 0) ? OP_CONTROL :
                              ($urandom_range(1) == 0) ? OP_INTR_IN : OP_ISO_OUT;
          r.packet_bytes    = '0;
          r.transfer_size   = SIZE_W'($urandom_range(65535));
        end
        1: begin  // empty data
          r.operation       = ($urandom_range(1) == 0) ? OP_INTR_IN : OP_ISO_OUT;
          r.packet_bytes    = MPS_W'($urandom_range(1023, 1));
          r.transfer_size   = '0;
        end
        default: begin  // far too many descriptors
          r.operation       = ($urandom_range(2) == 0) ? OP_CONTROL :
                              ($urandom_range(1) == 0) ? OP_INTR_IN : OP_ISO_OUT;
          r.packet_bytes    = MPS_W'($urandom_range(8, 1));
          r.transfer_size   = SIZE_W'($urandom_range(65535, 600));
        end
      endcase
    end else if (pick < 92) begin
      r.operation       = OP_NONE;
      r.packet_bytes    = MPS_W'($urandom_range(1023));
      r.transfer_size   = SIZE_W'($urandom_range(65535));
    end else begin
      r.operation       = 2'($urandom_range(3));
      r.packet_bytes    = MPS_W'($urandom_range(1023));
      r.transfer_size   = SIZE_W'($urandom_range(65535));
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Setup, data and status stages, with and without a data stage, in both
  // directions, and the largest chain that still fits.
  task automatic test_control_stages();
    send_request(make_request(OP_CONTROL, 1'b0, 7'd0, 4'd0, 8, 0, '0, '0));
    // no data stage with the data direction OUT: status is IN
    send_request(make_request(OP_CONTROL, 1'b1, 7'd127, 4'd15, 8, 0,
                              32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_request(make_request(OP_CONTROL, 1'b1, 7'd5, 4'd9, 64, 200,
                              32'h1000_0000, 32'h0000_0040));
    send_request(make_request(OP_CONTROL, 1'b0, 7'h55, 4'd0, 1023, 1023,
                              32'h8000_0000, 32'h7FFF_FFF8));
    send_request(make_request(OP_CONTROL, 1'b0, 7'h2A, 4'd3, 1, 62,
                              32'h0000_1000, 32'h0000_2000));
  endtask

  // IN chains with toggles from zero; full-size chain and address wrap.
  task automatic test_interrupt_in();
    send_request(make_request(OP_INTR_IN, 1'b0, 7'd127, 4'd15, 1023, 65472,
                              32'hA5A5_5A5A, '0));
    send_request(make_request(OP_INTR_IN, 1'b1, 7'd1, 4'd1, 1, 1, 32'hFFFF_FFFF, '0));
    send_request(make_request(OP_INTR_IN, 1'b0, 7'd9, 4'd8, 3, 10, 32'hFFFF_FFFE, '0));
  endtask

  // OUT chains with toggle held at zero and isochronous select.
  task automatic test_isochronous_out();
    send_request(make_request(OP_ISO_OUT, 1'b1, 7'd64, 4'd7, 100, 250, 32'h0000_1000, '0));
    send_request(make_request(OP_ISO_OUT, 1'b0, 7'd3, 4'd15, 1, 64, 32'h0F0F_0F0F, '0));
  endtask

  // Each error code, the boundary just past the limit, and the priority of
  // a zero packet size over empty data.
  task automatic test_error_codes();
    send_request(make_request(OP_CONTROL, 1'b1, 7'd2, 4'd0, 1, 63, '0, '0));
    send_request(make_request(OP_INTR_IN, 1'b0, 7'd4, 4'd2, 1, 65, '0, '0));
    send_request(make_request(OP_ISO_OUT, 1'b0, 7'd6, 4'd4, 1, 65, '0, '0));
    send_request(make_request(OP_INTR_IN, 1'b0, 7'd8, 4'd6, 1023, 65535, '0, '0));
    send_request(make_request(OP_CONTROL, 1'b0, 7'd10, 4'd0, 2, 65535, '0, '0));
    send_request(make_request(OP_INTR_IN, 1'b0, 7'd11, 4'd1, 16, 0, '0, '0));
    send_request(make_request(OP_ISO_OUT, 1'b1, 7'd12, 4'd2, 512, 0, '0, '0));
    send_request(make_request(OP_INTR_IN, 1'b0, 7'd13, 4'd3, 0, 0, '0, '0));
    send_request(make_request(OP_CONTROL, 1'b1, 7'd14, 4'd0, 0, 100, '0, '0));
    send_request(make_request(OP_ISO_OUT, 1'b0, 7'd15, 4'd5, 0, 65535, '0, '0));
  endtask

  // Operation three must be swallowed without a beat.
  task automatic test_ignored_operation();
    send_request(make_request(OP_NONE, 1'b1, 7'd127, 4'd15, 1023, 65535,
                              32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_request(make_request(OP_NONE, 1'b0, 7'd0, 4'd0, 0, 0, '0, '0));
    // a real request straight after, to show nothing was left behind
    send_request(make_request(OP_INTR_IN, 1'b0, 7'd33, 4'd12, 8, 20, 32'h0000_0100, '0));
  endtask

  // Random traffic under one idle and stall setting; ignored requests are not
  // counted towards the number asked for.
  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input int requests);
    in_t req;
    int  counted;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    counted        = 0;
    while (counted < requests) begin
      req = random_request();
      send_request(req);
      if (req.operation != OP_NONE) counted++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_control_stages();
    test_interrupt_in();
    test_isochronous_out();
    test_error_codes();
    test_ignored_operation();
    wait_for_chains();

    test_random_traffic(0, 0, 81);
    wait_for_chains();
    test_random_traffic(78, 0, 81);
    wait_for_chains();
    test_random_traffic(0, 78, 81);
    wait_for_chains();
    test_random_traffic(12, 12, 82);
    wait_for_chains();

    // let any stray beat show itself before the verdict
    repeat (HOLD_OFF) @(posedge clk);
    if (pending_descriptors.size() != 0) begin
      $error("%0d descriptors never arrived", pending_descriptors.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("** usb_transfer_descriptor_builder: PASSED **");
    end else begin
      $display("** usb_transfer_descriptor_builder: FAILED **");
    end
    $finish;
  end

endmodule
